### design/tebf_pkg.sv
// shared types, format codes and constants for the bfloat16 converter
// no dependencies; used by the converter top level and its checker
`timescale 1ns / 1ps

package tebf_pkg;

   // source format codes held in the format register
   localparam logic [1:0] FMT_BF16 = 2'd0;
   localparam logic [1:0] FMT_F32  = 2'd1;
   localparam logic [1:0] FMT_F16  = 2'd2;

   localparam int unsigned FMT_W = 2;

   // rounding bias before adding the kept lsb
   localparam logic [31:0] ROUND_BIAS = 32'h0000_7FFF;
   // f16 to f32 exponent rebias (127 - 15)
   localparam logic [7:0]  EXP_REBIAS = 8'd112;
   localparam logic [7:0]  F32_EXP_MAX = 8'hFF;
   localparam logic [4:0]  F16_EXP_MAX = 5'h1F;

   typedef struct packed {
      logic [31:0] raw_word;
      logic        last_in;
   } req_type;

   typedef struct packed {
      logic [15:0] bf16_bits;
      logic        last_out;
   } rsp_type;

   // leading zeros of a 10-bit f16 mantissa, 10 when all zero
   function automatic logic [3:0] lzc10(input logic [9:0] man);
      logic [3:0] cnt;
      logic       found;
      cnt   = 4'd10;
      found = 1'b0;
      for (int i = 9; i >= 0; i--) begin
         if (!found && man[i]) begin
            cnt   = 4'(9 - i);
            found = 1'b1;
         end
      end
      return cnt;
   endfunction

endpackage

### design/tensor_element_to_bf16.sv
// tensor element to bfloat16 converter, three-stage pipeline
// depends on tebf_pkg for request/response types, format codes and constants
`timescale 1ns / 1ps

// a taken request passes the stage 1, stage 2 and stage 3 registers before strobe goes high
// throughput: 1 request per cycle; each stage holds one request and the receiver cannot stall
// stage 1 counts leading zeros, stage 2 widens f16 to f32, stage 3 does the rounding add
// busy is high only during reset, so a request can start in any other cycle
// synchronous active-high reset clears the stage valid bits and sets the format to bf16
module tensor_element_to_bf16 (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  tebf_pkg::req_type    req_data,
   // response channel
   output logic                 strobe,
   output tebf_pkg::rsp_type    rsp_data,
   // format register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [tebf_pkg::FMT_W-1:0] csr_data
);

   // format register
   logic [tebf_pkg::FMT_W-1:0] fmt_ff;

   // stage 1: captured request plus leading zero count
   logic                       s1_valid_ff;
   logic [31:0]                s1_word_ff;
   logic                       s1_last_ff;
   logic [tebf_pkg::FMT_W-1:0] s1_fmt_ff;
   logic [3:0]                 s1_lz_ff;
   logic [3:0]                 s1_lz_in;

   // stage 2: word widened to f32 where the format is f16
   logic                       s2_valid_ff;
   logic [31:0]                s2_word_ff;
   logic                       s2_last_ff;
   logic [tebf_pkg::FMT_W-1:0] s2_fmt_ff;
   logic [31:0]                s2_word_in;

   // stage 3: rounded output
   logic                       strobe_ff;
   tebf_pkg::rsp_type          rsp_ff;
   tebf_pkg::rsp_type          rsp_in;

   // f16 fields seen in stage 2
   logic                       h_sign;
   logic [4:0]                 h_exp;
   logic [9:0]                 h_man;
   logic [9:0]                 h_norm;
   logic [7:0]                 h_sub_exp;

   // rounding add in stage 3
   logic [31:0]                round_sum;

   logic                       accept;

   // no request is taken while reset is held
   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // format register; the user must write it only while the pipeline is empty, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= tebf_pkg::FMT_BF16;
      end else if (csr_valid && csr_ready) begin
         fmt_ff <= csr_data;
      end
   end

   // stage 1: leading zero count of the f16 mantissa, used only for subnormals
   assign s1_lz_in = tebf_pkg::lzc10(req_data.raw_word[9:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_data.raw_word;
         s1_last_ff <= req_data.last_in;
         s1_fmt_ff  <= fmt_ff;
         s1_lz_ff   <= s1_lz_in;
      end
   end

   // stage 2: exact widening of an f16 value to f32
   assign h_sign    = s1_word_ff[15];
   assign h_exp     = s1_word_ff[14:10];
   assign h_man     = s1_word_ff[9:0];
   // subnormal: shift the leading one out of the field, exponent 1 - shifts rebiased
   assign h_norm    = 10'(h_man << (s1_lz_ff + 4'd1));
   assign h_sub_exp = tebf_pkg::EXP_REBIAS - {4'd0, s1_lz_ff};

   always_comb begin
      if (s1_fmt_ff != tebf_pkg::FMT_F16) begin
         // f32 and bf16 keep the word as taken
         s2_word_in = s1_word_ff;
      end else if (h_exp == 5'd0) begin
         if (h_man == 10'd0) begin
            // signed zero
            s2_word_in = {h_sign, 31'd0};
         end else begin
            s2_word_in = {h_sign, h_sub_exp, h_norm, 13'd0};
         end
      end else if (h_exp == tebf_pkg::F16_EXP_MAX) begin
         // infinity or nan, payload kept on top of the mantissa
         s2_word_in = {h_sign, tebf_pkg::F32_EXP_MAX, h_man, 13'd0};
      end else begin
         s2_word_in = {h_sign, {3'd0, h_exp} + tebf_pkg::EXP_REBIAS, h_man, 13'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_word_ff <= s2_word_in;
         s2_last_ff <= s1_last_ff;
         s2_fmt_ff  <= s1_fmt_ff;
      end
   end

   // stage 3: round to nearest even, sum wraps at 32 bits
   assign round_sum = s2_word_ff + tebf_pkg::ROUND_BIAS + {31'd0, s2_word_ff[16]};

   always_comb begin
      rsp_in.last_out = s2_last_ff;
      case (s2_fmt_ff)
         tebf_pkg::FMT_BF16: begin
            rsp_in.bf16_bits = s2_word_ff[15:0];
         end
         tebf_pkg::FMT_F32, tebf_pkg::FMT_F16: begin
            rsp_in.bf16_bits = round_sum[31:16];
         end
         default: begin
            // unused format code gives zero
            rsp_in.bf16_bits = 16'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign strobe   = strobe_ff;
   assign rsp_data = rsp_ff;

endmodule

### design/tebf_checker.sv
// port-level checker for the bfloat16 converter, bound to the top level
// depends on tebf_pkg for types and format codes
`timescale 1ns / 1ps

module tebf_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  tebf_pkg::req_type    req_data,
   input  logic                 strobe,
   input  tebf_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [tebf_pkg::FMT_W-1:0] csr_data
);

   // shadow of the format register
   logic [tebf_pkg::FMT_W-1:0] fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= tebf_pkg::FMT_BF16;
      end else if (csr_valid && csr_ready) begin
         fmt_ff <= csr_data;
      end
   end

   // every taken request is followed by a response strobe
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 strobe)
      else $error("taken request gave no response");

   // no response without an earlier taken request
   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      strobe |-> $past(start && !busy, 3))
      else $error("response without request");

   // last flag travels with its element
   a_last_copy: assert property (@(posedge clock) disable iff (reset)
      strobe |-> (rsp_data.last_out == $past(req_data.last_in, 3)))
      else $error("last flag mismatch");

   // bf16 source passes the low half through
   a_bf16_pass: assert property (@(posedge clock) disable iff (reset)
      (strobe && fmt_ff == tebf_pkg::FMT_BF16)
         |-> (rsp_data.bf16_bits == $past(req_data.raw_word[15:0], 3)))
      else $error("bf16 passthrough mismatch");

endmodule

bind tensor_element_to_bf16 tebf_checker u_tebf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .strobe    (strobe),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);

### tb/tb.sv
// self-checking bench for tensor_element_to_bf16: directed table, then random phases
// depends on tebf_pkg for request/response types and format codes, plus the converter rtl
`timescale 1ns / 1ps

module tb;

   // format code with no conversion path, converts to zero
   localparam logic [1:0] FMT_UNUSED = 2'd3;
   // f16 exponent rebias into f32 (127 - 15)
   localparam int HALF_REBIAS = 112;
   localparam int N_DIRECTED = 25;
   localparam int N_PHASES = 8;
   localparam int PHASE_REQUESTS = 238;
   // pipeline depth plus margin, used for the tail wait; DRAIN_LIMIT bounds the drain
   localparam int TAIL_CYCLES = 8;
   localparam int DRAIN_LIMIT = 1000;

   // one directed request, with the expected bits typed in when obvious
   typedef struct packed {
      logic [1:0]  fmt;
      logic [31:0] raw;
      logic        last;
      logic        typed;
      logic [15:0] bits;
   } stim_row_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   tebf_pkg::req_type             req_data = '0;
   logic                          strobe;
   tebf_pkg::rsp_type             rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [tebf_pkg::FMT_W-1:0]    csr_data = '0;

   // shadow of the format register, updated on each accepted write
   logic [1:0]          shadow_format = tebf_pkg::FMT_BF16;
   // converted elements still owed by the block, oldest first
   tebf_pkg::rsp_type   pending_bf16[$];
   int                  mismatches = 0;

   // rows are grouped by format; the leading bf16 rows rely on the reset value
   stim_row_type directed_rows [N_DIRECTED] = '{
      // bf16 passthrough, upper half ignored
      '{tebf_pkg::FMT_BF16, 32'h0000_0000, 1'b0, 1'b1, 16'h0000},
      '{tebf_pkg::FMT_BF16, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF},
      '{tebf_pkg::FMT_BF16, 32'hABCD_1234, 1'b0, 1'b1, 16'h1234},
      // f32 rounding: zero, one, ties both ways, nan into inf, overflow, wrap
      '{tebf_pkg::FMT_F32,  32'h0000_0000, 1'b0, 1'b1, 16'h0000},
      '{tebf_pkg::FMT_F32,  32'h3F80_0000, 1'b0, 1'b1, 16'h3F80},
      '{tebf_pkg::FMT_F32,  32'h3F80_8000, 1'b0, 1'b0, 16'h0000},
      '{tebf_pkg::FMT_F32,  32'h3F81_8000, 1'b1, 1'b0, 16'h0000},
      '{tebf_pkg::FMT_F32,  32'h7F80_0001, 1'b0, 1'b1, 16'h7F80},
      '{tebf_pkg::FMT_F32,  32'h7FC0_0000, 1'b0, 1'b1, 16'h7FC0},
      '{tebf_pkg::FMT_F32,  32'h7F7F_FFFF, 1'b0, 1'b0, 16'h0000},
      '{tebf_pkg::FMT_F32,  32'hFFFF_8000, 1'b1, 1'b1, 16'h0000},
      '{tebf_pkg::FMT_F32,  32'hFFFF_FFFF, 1'b0, 1'b1, 16'h0000},
      '{tebf_pkg::FMT_F32,  32'h0000_FFFF, 1'b0, 1'b0, 16'h0000},
      // f16 widening: signed zeros, upper half ignored, inf, nan, subnormals, max
      '{tebf_pkg::FMT_F16,  32'h0000_0000, 1'b0, 1'b1, 16'h0000},
      '{tebf_pkg::FMT_F16,  32'h0000_8000, 1'b1, 1'b1, 16'h8000},
      '{tebf_pkg::FMT_F16,  32'h0000_3C00, 1'b0, 1'b1, 16'h3F80},
      '{tebf_pkg::FMT_F16,  32'hFFFF_3C00, 1'b0, 1'b1, 16'h3F80},
      '{tebf_pkg::FMT_F16,  32'h0000_7C00, 1'b0, 1'b1, 16'h7F80},
      '{tebf_pkg::FMT_F16,  32'h0000_FC00, 1'b1, 1'b1, 16'hFF80},
      '{tebf_pkg::FMT_F16,  32'h0000_7E00, 1'b0, 1'b1, 16'h7FC0},
      '{tebf_pkg::FMT_F16,  32'h0000_0001, 1'b0, 1'b0, 16'h0000},
      '{tebf_pkg::FMT_F16,  32'h0000_83FF, 1'b0, 1'b0, 16'h0000},
      '{tebf_pkg::FMT_F16,  32'h0000_7BFF, 1'b1, 1'b0, 16'h0000},
      // unused code gives zero bits, last still copied
      '{FMT_UNUSED,         32'h3F80_0000, 1'b1, 1'b1, 16'h0000},
      '{FMT_UNUSED,         32'hFFFF_FFFF, 1'b0, 1'b1, 16'h0000}
   };

   tensor_element_to_bf16 u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .strobe    (strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // round to nearest even on the upper half; the add wraps at 32 bits
   function automatic logic [15:0] round_to_bf16(input logic [31:0] w);
      logic [31:0] sum;
      sum = w + 32'h0000_7FFF + {31'b0, w[16]};
      return sum[31:16];
   endfunction

   // exact f16 to f32 widening
   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [10:0] mant;
      int          shifts;
      sgn    = {h[15], 31'b0};
      ex     = h[14:10];
      mant   = {1'b0, h[9:0]};
      shifts = 0;
      if (ex == 5'd0) begin
         if (mant == 11'd0) return sgn;
         // normalize the subnormal until the hidden bit shows up
         while (!mant[10]) begin
            mant   = mant << 1;
            shifts = shifts + 1;
         end
         return sgn | (32'(1 + HALF_REBIAS - shifts) << 23) | (32'(mant[9:0]) << 13);
      end
      if (ex == 5'h1F) return sgn | 32'h7F80_0000 | (32'(mant[9:0]) << 13);
      return sgn | (32'(int'(ex) + HALF_REBIAS) << 23) | (32'(mant[9:0]) << 13);
   endfunction

   function automatic logic [15:0] convert_element(input logic [1:0] fmt,
                                                  input logic [31:0] raw);
      case (fmt)
         tebf_pkg::FMT_BF16: return raw[15:0];
         tebf_pkg::FMT_F32:  return round_to_bf16(raw);
         tebf_pkg::FMT_F16:  return round_to_bf16(widen_half(raw[15:0]));
         default:            return 16'h0000;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, what, want, got);
   endtask

   // result checker: sampled at the edge that ends the strobe cycle
   always @(posedge clock) begin
      tebf_pkg::rsp_type want;
      if (!reset && strobe !== 1'b0) begin
         if (pending_bf16.size() == 0) begin
            report_mismatch("unexpected result", 16'h0000, rsp_data.bf16_bits);
         end else begin
            want = pending_bf16.pop_front();
            if (rsp_data.bf16_bits !== want.bf16_bits)
               report_mismatch("bf16_bits", want.bf16_bits, rsp_data.bf16_bits);
            if (rsp_data.last_out !== want.last_out)
               report_mismatch("last_out", {15'b0, want.last_out},
                               {15'b0, rsp_data.last_out});
         end
      end
   end

   // present one request after an idle gap; start stays high into the next request
   // unless that one idles first
   task automatic send_element(input logic [31:0] raw, input logic last, input int gap,
                               input logic typed, input logic [15:0] typed_bits);
      tebf_pkg::rsp_type want;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{raw_word: raw, last_in: last};
      do @(posedge clock); while (busy !== 1'b0);
      want.bf16_bits = typed ? typed_bits : convert_element(shadow_format, raw);
      want.last_out  = last;
      pending_bf16 = {pending_bf16, want};
   endtask

   // wait until every owed result has come, bounded
   task automatic drain_results();
      int waited;
      waited = 0;
      start <= 1'b0;
      while (pending_bf16.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_bf16.size() != 0) begin
         report_mismatch("results never arrived", 16'(pending_bf16.size()), 16'h0000);
         pending_bf16.delete();
      end
   endtask

   // format writes only with the pipeline empty
   task automatic write_format(input logic [1:0] fmt);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= fmt;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      shadow_format = fmt;
   endtask

   // random element word with the interesting encodings weighted in
   function automatic logic [31:0] random_word(input logic [1:0] fmt);
      logic [31:0] w;
      int          pick;
      w    = $urandom;
      pick = $urandom_range(0, 5);
      if (fmt == tebf_pkg::FMT_F32) begin
         case (pick)
            1: w[30:23] = 8'hFF;                                  // inf and nan
            2: w[15:0]  = 16'h8000;                               // exact ties
            3: w[15:0]  = 16'h7FFF + 16'($urandom_range(0, 2));   // around the tie
            4: w[31:16] = 16'hFFFF;                               // sum wraps
            5: w[30:23] = 8'h00;                                  // zero and denormal
            default: ;
         endcase
      end else begin
         case (pick)
            1: w[14:10] = 5'h00;                                  // f16 subnormal
            2: w[14:10] = 5'h1F;                                  // f16 inf and nan
            3: w[14:0]  = 15'(1) << $urandom_range(0, 9);         // single-bit subnormal
            4: w[14:0]  = 15'h0000;                               // signed zero
            default: ;
         endcase
      end
      return w;
   endfunction

   initial begin
      logic [1:0] phase_fmt;
      logic       quiet;
      int         gap;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table: format changes go through the write channel when idle
      for (int i = 0; i < N_DIRECTED; i++) begin
         if (directed_rows[i].fmt != shadow_format) write_format(directed_rows[i].fmt);
         send_element(directed_rows[i].raw, directed_rows[i].last, $urandom_range(0, 2),
                      directed_rows[i].typed, directed_rows[i].bits);
      end

      // random phases: bf16 and the unused code get written explicitly too
      quiet = 1'b0;
      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: phase_fmt = tebf_pkg::FMT_F32;
            1: phase_fmt = tebf_pkg::FMT_F16;
            2: phase_fmt = tebf_pkg::FMT_BF16;
            3: phase_fmt = FMT_UNUSED;
            default: phase_fmt = 2'($urandom_range(0, 3));
         endcase
         write_format(phase_fmt);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            // switch between back-to-back stretches and idling stretches
            if (n % 32 == 0) quiet = ($urandom_range(0, 2) == 0);
            gap = quiet ? 0 : $urandom_range(0, 15);
            send_element(random_word(phase_fmt), 1'($urandom_range(0, 1)), gap,
                         1'b0, 16'h0000);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tensor_element_to_bf16: match");
      else
         $display("tensor_element_to_bf16: mismatch");
      $finish;
   end

   // watchdog, far above the slowest correct run
   initial begin
      #10_000_000;
      $display("tensor_element_to_bf16: mismatch");
      $finish;
   end

endmodule
